### rtl/gfbl_pkg.sv
// ----------------------------------------------------------------------------
// gfbl_pkg
// Shared constants, codes and control types of the grouped free block list.
// ----------------------------------------------------------------------------
package gfbl_pkg;

    localparam int GROUP_SIZE  = 16;
    localparam int BLOCK_COUNT = 1024;

    localparam int ID_W    = 10;
    localparam int OP_W    = 2;
    localparam int GRP_W   = $clog2(GROUP_SIZE);
    localparam int CNT_W   = $clog2(GROUP_SIZE + 1);
    localparam int SLOT_W  = $clog2(BLOCK_COUNT);
    localparam int SPILL_AW = SLOT_W + GRP_W;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_FREE  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        logic reload_start;
        logic spill_wr;
        logic spill_done;
        logic rl_rd;
        logic rl_wr;
        logic rl_done;
        logic out_load;
        logic out_fail;
        logic out_grant;
        t_cnt step;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic top_zero;
    } t_stat;

endpackage

### rtl/grouped_free_block_list_top.sv
// ----------------------------------------------------------------------------
// grouped_free_block_list_top
// Latency: the result beat is valid the cycle after the input beat is taken.
// Throughput: one plain free, allocate or clear per cycle while results are
// taken; a free onto a full group first copies the stack to the spill store,
// an allocate of the last entry reloads it (spill store reads, one per cycle).
// Reset: synchronous active low; stack zeroed, count 1, spill store untouched.
// ----------------------------------------------------------------------------
module grouped_free_block_list_top
    import gfbl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // operation[1:0], block_id[11:2]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // ok[0], granted_block[10:1]
);

    t_cmd w_cmd;
    t_stat w_stat;
    logic  w_ok;
    t_id   w_granted;

    gfbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tdata[OP_W-1:0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gfbl_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_blk     (i_s_tdata[OP_W+ID_W-1:OP_W]),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_ok      (w_ok),
        .o_granted (w_granted)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - ID_W - 1){1'b0}}, w_granted, w_ok};

endmodule

### rtl/gfbl_ctrl.sv
// ----------------------------------------------------------------------------
// gfbl_ctrl
// Sequencer: handshakes, operation decode, spill and reload sweeps.
// ----------------------------------------------------------------------------
module gfbl_ctrl
    import gfbl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [OP_W-1:0] i_op,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  t_stat           i_stat,
    output t_cmd            o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SPILL  = 2'd1;
    localparam logic [1:0] ST_RELOAD = 2'd2;

    localparam t_cnt STEP_LAST = t_cnt'(GROUP_SIZE - 1);
    localparam t_cnt STEP_END  = t_cnt'(GROUP_SIZE);

    logic [1:0] r_state, n_state;
    t_cnt       r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       w_acc;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.step  = r_step;

        if (w_acc) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    o_cmd.out_load = 1'b1;
                    n_step = '0;
                    unique case (i_op)
                        OP_FREE: begin
                            if (i_stat.full) begin
                                n_state = ST_SPILL;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        OP_ALLOC: begin
                            if (i_stat.top_zero) begin
                                o_cmd.out_fail = 1'b1;
                            end else begin
                                o_cmd.out_grant = 1'b1;
                                if (i_stat.last) begin
                                    o_cmd.reload_start = 1'b1;
                                    n_state = ST_RELOAD;
                                end else begin
                                    o_cmd.pop = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SPILL: begin
                o_cmd.spill_wr = 1'b1;
                n_step = r_step + t_cnt'(1);
                if (r_step == STEP_LAST) begin
                    o_cmd.spill_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RELOAD: begin
                o_cmd.rl_rd = (r_step != STEP_END);
                o_cmd.rl_wr = (r_step != '0);
                n_step = r_step + t_cnt'(1);
                if (r_step == STEP_END) begin
                    o_cmd.rl_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/gfbl_dp.sv
// ----------------------------------------------------------------------------
// gfbl_dp
// Datapath: group stack, count, spill store and result register.
// ----------------------------------------------------------------------------
module gfbl_dp
    import gfbl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_id   i_blk,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_ok,
    output t_id   o_granted
);

    t_id  r_stack [GROUP_SIZE];
    t_cnt r_count;
    t_id  r_blk;
    t_id  r_src;
    t_id  r_rd_data;
    logic r_ok;
    t_id  r_granted;

    t_id  spill_mem [GROUP_SIZE * BLOCK_COUNT];

    logic [GRP_W-1:0]    w_top_idx;
    logic [GRP_W-1:0]    w_idx;
    logic [GRP_W-1:0]    w_wr_idx;
    logic [GRP_W-1:0]    w_push_idx;
    t_id                 w_top_val;
    t_id                 w_spill_val;
    t_cnt                w_step_m1;
    logic [SPILL_AW-1:0] w_spill_addr;
    logic [SPILL_AW-1:0] w_load_addr;

    assign w_top_idx   = GRP_W'(r_count - t_cnt'(1));
    assign w_push_idx  = GRP_W'(r_count);
    assign w_idx       = i_cmd.step[GRP_W-1:0];
    assign w_step_m1   = i_cmd.step - t_cnt'(1);
    assign w_wr_idx    = w_step_m1[GRP_W-1:0];
    assign w_top_val   = r_stack[w_top_idx];
    assign w_spill_val = r_stack[w_idx];

    assign w_spill_addr = {r_blk[SLOT_W-1:0], w_idx};
    assign w_load_addr  = {r_src[SLOT_W-1:0], w_idx};

    assign o_stat.full     = (r_count == t_cnt'(GROUP_SIZE));
    assign o_stat.last     = (r_count == t_cnt'(1));
    assign o_stat.top_zero = (w_top_val == '0);

    assign o_ok      = r_ok;
    assign o_granted = r_granted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= t_cnt'(1);
            for (int k = 0; k < GROUP_SIZE; k++) begin
                r_stack[k] <= '0;
            end
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + t_cnt'(1);
                r_stack[w_push_idx] <= i_blk;
            end
            if (i_cmd.pop) begin
                r_count <= r_count - t_cnt'(1);
            end
            if (i_cmd.clear) begin
                r_count <= t_cnt'(1);
                r_stack[0] <= '0;
            end
            if (i_cmd.spill_done) begin
                r_count <= t_cnt'(1);
                r_stack[0] <= r_blk;
            end
            if (i_cmd.rl_wr) begin
                r_stack[w_wr_idx] <= r_rd_data;
            end
            if (i_cmd.rl_done) begin
                r_count <= t_cnt'(GROUP_SIZE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_blk     <= i_blk;
            r_ok      <= !i_cmd.out_fail;
            r_granted <= i_cmd.out_grant ? w_top_val : '0;
        end
        if (i_cmd.reload_start) begin
            r_src <= w_top_val;
        end
    end

    // spill store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.spill_wr) begin
            spill_mem[w_spill_addr] <= w_spill_val;
        end
        if (i_cmd.rl_rd) begin
            r_rd_data <= spill_mem[w_load_addr];
        end
    end

endmodule
